[sv/ppagc_pkg.sv]
// shared types, register codes and reset values for the peak-to-peak stepped agc
package ppagc_pkg;

  localparam int SampleW = 8;
  localparam int GainW = 3;
  localparam int WinLenW = 16;
  localparam int CfgIndexW = 4;
  localparam int CfgDataW = 16;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [GainW-1:0] gain_t;
  typedef logic [WinLenW-1:0] win_len_t;
  typedef logic [CfgIndexW-1:0] cfg_index_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // register indexes
  localparam cfg_index_t RegWindowLength = 4'd0;
  localparam cfg_index_t RegHighThreshold = 4'd1;
  localparam cfg_index_t RegLowThreshold = 4'd2;
  localparam cfg_index_t RegStartLevel = 4'd3;

  // reset values
  localparam win_len_t ResetWindowLength = 16'd500;
  localparam sample_t ResetHighThreshold = 8'd230;
  localparam sample_t ResetLowThreshold = 8'd100;
  localparam sample_t ResetStartLevel = 8'd128;

endpackage

[sv/ppagc_if.sv]
// stream and configuration interfaces of the peak-to-peak stepped agc
interface ppagc_sample_if import ppagc_pkg::*; ();
  logic valid;
  logic ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ppagc_result_if import ppagc_pkg::*; ();
  logic valid;
  logic ready;
  gain_t gain_step;
  sample_t peak_to_peak;
  modport source (output valid, output gain_step, output peak_to_peak, input ready);
  modport sink (input valid, input gain_step, input peak_to_peak, output ready);
endinterface

interface ppagc_cfg_if import ppagc_pkg::*; ();
  logic valid;
  logic ready;
  cfg_index_t index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/peak_to_peak_stepped_agc_top.sv]
// peak-to-peak stepped agc: window min/max tracking and gain stepping
// result: a window-closing sample's result is loaded into the output register when the sample is accepted
// throughput: one sample request per cycle; the only stall is a closing sample
//   arriving while the previous result still sits unread in the output register
// reset: rst is synchronous, active high; registers return to their reset
//   values, trackers to level 128, the sample count to zero, gain to the top step
module peak_to_peak_stepped_agc_top import ppagc_pkg::*; #(
  parameter int GAIN_STEPS_MAX = 7
) (
  input logic clk,
  input logic rst,
  ppagc_sample_if.sink samples,
  ppagc_result_if.source results,
  ppagc_cfg_if.sink cfg
);

  // top gain step, held to what the 3-bit field can carry
  localparam gain_t GainTop = (GAIN_STEPS_MAX > 7) ? gain_t'(7) : gain_t'(GAIN_STEPS_MAX);

  // configuration registers
  win_len_t window_length;
  sample_t high_threshold;
  sample_t low_threshold;
  sample_t start_level;

  // window state
  sample_t window_min;
  sample_t window_max;
  win_len_t samples_seen;
  gain_t gain_level;

  // result register
  logic res_valid;
  gain_t res_gain;
  sample_t res_pp;

  // combinational path for one sample request
  logic accept;
  logic first;
  logic closes;
  sample_t base_min;
  sample_t base_max;
  sample_t window_min_next;
  sample_t window_max_next;
  logic [WinLenW:0] count;
  logic [WinLenW:0] len;
  sample_t pp;
  gain_t gain_lowered;
  gain_t gain_level_next;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  // a new window starts from the start level, read at its first sample
  assign first = (samples_seen == '0);
  assign base_min = first ? start_level : window_min;
  assign base_max = first ? start_level : window_max;
  assign window_max_next = (samples.sample > base_max) ? samples.sample : base_max;
  assign window_min_next = (samples.sample < base_min) ? samples.sample : base_min;

  // zero length acts as one; a shortened window closes at once
  assign count = {1'b0, samples_seen} + 1'b1;
  assign len = (window_length == '0) ? (WinLenW+1)'(1) : {1'b0, window_length};
  assign closes = (count >= len);

  // lower first, then raise, both saturating
  assign pp = window_max_next - window_min_next;
  assign gain_lowered = ((pp > high_threshold) && (gain_level != '0)) ?
                        gain_level - 1'b1 : gain_level;
  assign gain_level_next = ((pp < low_threshold) && (gain_lowered < GainTop)) ?
                           gain_lowered + 1'b1 : gain_lowered;

  // stall only a closing sample that would overwrite an unread result
  assign samples.ready = !closes || !res_valid || results.ready;
  assign accept = samples.valid && samples.ready;

  assign results.valid = res_valid;
  assign results.gain_step = res_gain;
  assign results.peak_to_peak = res_pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= ResetWindowLength;
      high_threshold <= ResetHighThreshold;
      low_threshold <= ResetLowThreshold;
      start_level <= ResetStartLevel;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegWindowLength: window_length <= cfg.data;
        RegHighThreshold: high_threshold <= cfg.data[SampleW-1:0];
        RegLowThreshold: low_threshold <= cfg.data[SampleW-1:0];
        RegStartLevel: start_level <= cfg.data[SampleW-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_min <= ResetStartLevel;
      window_max <= ResetStartLevel;
      samples_seen <= '0;
      gain_level <= GainTop;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        window_min <= window_min_next;
        window_max <= window_max_next;
        if (closes) begin
          samples_seen <= '0;
          gain_level <= gain_level_next;
        end else begin
          samples_seen <= count[WinLenW-1:0];
        end
      end
      if (accept && closes) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded when a window closes
  always_ff @(posedge clk) begin
    if (accept && closes) begin
      res_gain <= gain_level_next;
      res_pp <= pp;
    end
  end

endmodule
